// ----- sv/line_position_steering_core_macros.svh -----
// ----------------------------------------------------------------------------
// line position steering core assertion macros
// concurrent checks on the rising edge of clk, reporting through $error
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_STEERING_CORE_MACROS_SVH
`define LINE_POSITION_STEERING_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset only
`define LPS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define LPS_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LPS_ASSERT(name, prop, msg)
`define LPS_ASSERT_RST(name, prop, msg)

`endif

`endif

// ----- sv/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// types, widths and constants of the line position steering core
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int CHANNELS    = 6;
    localparam int SAMPLE_BITS = 12;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 20;
    localparam int SPEED_W     = 15;
    localparam int GAIN_W      = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // q1.15 channel levels, 0..1.0 inclusive
    localparam int Q15_BITS = 15;
    localparam int Q15_W    = Q15_BITS + 1;
    localparam logic [Q15_W-1:0] Q15_ONE = Q15_W'(1 << Q15_BITS);

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SPAN_W   = SAMPLE_BITS + 1;
    localparam int WEIGHT_W = $clog2(CHANNELS) + 2;

    // weighted sum bound: sum of |2i-(C-1)| is at most C*C/2
    localparam int WSUM_MAX = (CHANNELS * CHANNELS) / 2;
    localparam int FRESH_W  = $clog2(WSUM_MAX * (1 << Q15_BITS) + 1) + 1;

    // 9*avg + fresh
    localparam int T_W      = (((POS_W + 4) > FRESH_W) ? (POS_W + 4) : FRESH_W) + 1;
    localparam int DIV_W    = T_W;
    localparam int DVS_W    = (SAMPLE_BITS > 4) ? SAMPLE_BITS : 4;
    localparam int CNT_W    = $clog2(DIV_W + 1);

    localparam int AVG_KEEP    = 9;
    localparam int AVG_DIVISOR = 10;

    // divide by ten as multiply by ceil(2^27/10), exact for magnitudes below 2^26
    localparam int AVG_RECIP_SHIFT = 27;
    localparam int AVG_RECIP_W     = 24;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((1 << AVG_RECIP_SHIFT) + AVG_DIVISOR - 1) / AVG_DIVISOR);
    localparam int RECIP_PROD_W    = DIV_W + AVG_RECIP_W;

    localparam logic signed [T_W-1:0] AVG_HI = T_W'((1 << (POS_W - 1)) - 1);
    localparam logic signed [T_W-1:0] AVG_LO = T_W'(-(1 << (POS_W - 1)));

    // largest magnitude a smoothed position can reach from the weighted sum
    localparam logic signed [T_W-1:0] POS_BOUND =
        T_W'(((CHANNELS * CHANNELS) / 4) * (1 << Q15_BITS));

    localparam int PROD_W     = POS_W + GAIN_W + 1;
    localparam int GAIN_SHIFT = 16;
    localparam int DIFF_W     = PROD_W - GAIN_SHIFT;
    localparam int SPD_CALC_W = DIFF_W + 1;
    localparam logic signed [PROD_W-1:0] GAIN_BIAS = PROD_W'((1 << GAIN_SHIFT) - 1);

    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WHITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BLACK = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_STEER_GAIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED = 2'd1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(1000);
    localparam logic [SPEED_W-1:0] BASE_RESET = SPEED_W'(20000);

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        sample_t          sample_0;
        sample_t          sample_1;
        sample_t          sample_2;
        sample_t          sample_3;
        sample_t          sample_4;
        sample_t          sample_5;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [SPEED_W-1:0]      left_speed;
        logic [SPEED_W-1:0]      right_speed;
    } out_item_t;

    // centroid weight 2i-(C-1), in half sensor pitches
    function automatic logic signed [WEIGHT_W-1:0] channel_weight(input logic [CH_W-1:0] ch);
        return WEIGHT_W'(2 * int'(ch) - (CHANNELS - 1));
    endfunction

endpackage

// ----- sv/line_position_steering_core.sv -----
// ----------------------------------------------------------------------------
// line_position_steering_core
// six channel reflectance line sensor: calibration capture, weighted centroid,
// first order smoothing and proportional differential wheel speeds
// ----------------------------------------------------------------------------
//  channel   direction   handshake               payload
//  in        sink        in_valid / in_ready     in_data   (command, six samples)
//  out       source      out_valid / out_ready   out_data  (position, wheel speeds)
//  cfg       sink        cfg_write               cfg_index, cfg_data
//
//  a run scan goes from transfer to result through each channel in turn, the
//  15 step restoring divider only for a channel whose level needs it, and the
//  smoothing divide by ten is a single reciprocal multiply
//  capture scans and the unused command skip the channel and smoothing steps and return a result
//  in_ready is high only while idle; one finished result may wait in the output
//  register while the next scan is taken, and the sequencer holds if it is full
//  reset gives full scale white, zero black, zero position and default registers
// ----------------------------------------------------------------------------
`include "line_position_steering_core_macros.svh"

module line_position_steering_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  lps_pkg::in_item_t                     in_data,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output lps_pkg::out_item_t                    out_data,

    input  logic                                  cfg_write,
    input  logic [lps_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]        cfg_data
);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_CH_SETUP,
        ST_CH_DIV,
        ST_CH_ACC,
        ST_AVG_SETUP,
        ST_AVG_DIV,
        ST_AVG_DONE,
        ST_MUL,
        ST_SPEED,
        ST_OUT
    } state_t;

    state_t                               state_reg;
    logic                                 out_valid_reg;
    lps_pkg::out_item_t                   out_data_reg;

    logic [lps_pkg::GAIN_W-1:0]           gain_reg;
    logic [lps_pkg::SPEED_W-1:0]          base_reg;

    lps_pkg::sample_t                     white_reg [lps_pkg::CHANNELS];
    lps_pkg::sample_t                     black_reg [lps_pkg::CHANNELS];
    lps_pkg::sample_t                     scan_reg  [lps_pkg::CHANNELS];
    lps_pkg::sample_t                     scan_in   [lps_pkg::CHANNELS];
    logic signed [lps_pkg::POS_W-1:0]     smoothed_reg;

    logic [lps_pkg::CH_W-1:0]             ch_reg;
    logic [lps_pkg::CNT_W-1:0]            cnt_reg;
    logic [lps_pkg::DVS_W-1:0]            rem_reg;
    logic [lps_pkg::DVS_W-1:0]            divisor_reg;
    logic [lps_pkg::DIV_W-1:0]            quo_reg;
    logic [lps_pkg::Q15_W-1:0]            q_reg;
    logic signed [lps_pkg::FRESH_W-1:0]   acc_reg;
    logic                                 neg_reg;
    logic signed [lps_pkg::PROD_W-1:0]    prod_reg;
    logic [lps_pkg::SPEED_W-1:0]          left_reg;
    logic [lps_pkg::SPEED_W-1:0]          right_reg;

    logic                                 in_xfer;
    logic                                 out_load;
    logic                                 div_last;

    // channel setup
    lps_pkg::sample_t                     cur_x;
    lps_pkg::sample_t                     cur_white;
    lps_pkg::sample_t                     cur_black;
    logic signed [lps_pkg::SPAN_W-1:0]    span;
    logic signed [lps_pkg::SPAN_W-1:0]    num;
    logic signed [lps_pkg::SPAN_W-1:0]    span_neg;
    logic signed [lps_pkg::SPAN_W-1:0]    num_neg;
    logic [lps_pkg::SAMPLE_BITS-1:0]      span_mag;
    logic [lps_pkg::SAMPLE_BITS-1:0]      num_mag;
    logic                                 level_zero;
    logic                                 level_full;

    // restoring divider step
    logic [lps_pkg::DVS_W:0]              div_shift;
    logic [lps_pkg::DVS_W:0]              div_trial;
    logic                                 div_take;
    logic [lps_pkg::DVS_W-1:0]            rem_next;
    logic [lps_pkg::DIV_W-1:0]            quo_next;

    // accumulate
    logic signed [lps_pkg::FRESH_W-1:0]   q_ext;
    logic signed [lps_pkg::FRESH_W-1:0]   w_ext;
    logic signed [lps_pkg::FRESH_W-1:0]   term;

    // smoothing
    logic signed [lps_pkg::T_W-1:0]       s_ext;
    logic signed [lps_pkg::T_W-1:0]       t_sum;
    logic [lps_pkg::T_W-1:0]              t_mag;
    logic [lps_pkg::RECIP_PROD_W-1:0]     recip_prod;
    logic signed [lps_pkg::T_W-1:0]       avg_full;
    logic signed [lps_pkg::POS_W-1:0]     smoothed_next;

    // steering
    logic signed [lps_pkg::GAIN_W:0]      gain_s;
    logic signed [lps_pkg::PROD_W-1:0]    prod_adj;
    logic signed [lps_pkg::DIFF_W-1:0]    diff;
    logic signed [lps_pkg::SPD_CALC_W-1:0] diff_s;
    logic signed [lps_pkg::SPD_CALC_W-1:0] base_s;
    logic signed [lps_pkg::SPD_CALC_W-1:0] wheel;
    logic                                 diff_pos;
    logic [lps_pkg::SPEED_W-1:0]          wheel_clip;
    logic [lps_pkg::SPEED_W-1:0]          left_next;
    logic [lps_pkg::SPEED_W-1:0]          right_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign div_last  = (cnt_reg == lps_pkg::CNT_W'(1));

    assign scan_in[0] = in_data.sample_0;
    assign scan_in[1] = in_data.sample_1;
    assign scan_in[2] = in_data.sample_2;
    assign scan_in[3] = in_data.sample_3;
    assign scan_in[4] = in_data.sample_4;
    assign scan_in[5] = in_data.sample_5;

    // normalisation of the current channel
    assign cur_x     = scan_reg[ch_reg];
    assign cur_white = white_reg[ch_reg];
    assign cur_black = black_reg[ch_reg];
    assign span      = $signed({1'b0, cur_white}) - $signed({1'b0, cur_black});
    assign num       = $signed({1'b0, cur_x}) - $signed({1'b0, cur_black});
    assign span_neg  = -span;
    assign num_neg   = -num;
    assign span_mag  = span[lps_pkg::SPAN_W-1] ? span_neg[lps_pkg::SAMPLE_BITS-1:0]
                                               : span[lps_pkg::SAMPLE_BITS-1:0];
    assign num_mag   = num[lps_pkg::SPAN_W-1] ? num_neg[lps_pkg::SAMPLE_BITS-1:0]
                                              : num[lps_pkg::SAMPLE_BITS-1:0];
    // quotient zero, negative or undefined (zero span) clamps to zero
    assign level_zero = (span == '0) || (num == '0) ||
                        (span[lps_pkg::SPAN_W-1] != num[lps_pkg::SPAN_W-1]);
    // quotient at or above one clamps to one
    assign level_full = (num_mag >= span_mag);

    // restoring division, one quotient bit per cycle
    assign div_shift = {rem_reg, quo_reg[lps_pkg::DIV_W-1]};
    assign div_trial = div_shift - {1'b0, divisor_reg};
    assign div_take  = !div_trial[lps_pkg::DVS_W];
    assign rem_next  = div_take ? div_trial[lps_pkg::DVS_W-1:0] : div_shift[lps_pkg::DVS_W-1:0];
    assign quo_next  = {quo_reg[lps_pkg::DIV_W-2:0], div_take};

    assign q_ext = $signed(lps_pkg::FRESH_W'(q_reg));
    assign w_ext = lps_pkg::FRESH_W'(lps_pkg::channel_weight(ch_reg));
    assign term  = q_ext * w_ext;

    // 9*avg + fresh, split into sign and magnitude for the divide by ten
    assign s_ext = lps_pkg::T_W'(smoothed_reg);
    assign t_sum = s_ext * lps_pkg::T_W'(lps_pkg::AVG_KEEP) + lps_pkg::T_W'(acc_reg);
    assign t_mag = t_sum[lps_pkg::T_W-1] ? unsigned'(-t_sum) : unsigned'(t_sum);

    // magnitude held in quo_reg, quotient is the product shifted down
    assign recip_prod = quo_reg * lps_pkg::AVG_RECIP;

    assign avg_full = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    always_comb
    begin
        if (avg_full > lps_pkg::AVG_HI)
        begin
            smoothed_next = lps_pkg::POS_W'(lps_pkg::AVG_HI);
        end
        else if (avg_full < lps_pkg::AVG_LO)
        begin
            smoothed_next = lps_pkg::POS_W'(lps_pkg::AVG_LO);
        end
        else
        begin
            smoothed_next = lps_pkg::POS_W'(avg_full);
        end
    end

    // diff = avg*gain/65536 rounded toward zero
    assign gain_s   = $signed({1'b0, gain_reg});
    assign prod_adj = prod_reg + (prod_reg[lps_pkg::PROD_W-1] ? lps_pkg::GAIN_BIAS : '0);
    assign diff     = prod_adj[lps_pkg::PROD_W-1:lps_pkg::GAIN_SHIFT];
    assign diff_s   = lps_pkg::SPD_CALC_W'(diff);
    assign base_s   = $signed(lps_pkg::SPD_CALC_W'(base_reg));
    assign diff_pos = !diff[lps_pkg::DIFF_W-1] && (diff != '0);
    assign wheel    = diff_pos ? (base_s - diff_s) : (base_s + diff_s);
    assign wheel_clip = wheel[lps_pkg::SPD_CALC_W-1] ? '0 : wheel[lps_pkg::SPEED_W-1:0];
    assign left_next  = diff_pos ? wheel_clip : base_reg;
    assign right_next = diff_pos ? base_reg : wheel_clip;

    // sequencer, calibration and smoothed state, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            smoothed_reg  <= '0;
            for (int i = 0; i < lps_pkg::CHANNELS; i++)
            begin
                white_reg[i] <= '1;
                black_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= '{position: smoothed_reg, left_speed: left_reg,
                                   right_speed: right_reg};
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_data.command == lps_pkg::CMD_RUN)
                        begin
                            state_reg <= ST_CH_SETUP;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                        if (in_data.command == lps_pkg::CMD_WHITE)
                        begin
                            white_reg <= scan_in;
                        end
                        if (in_data.command == lps_pkg::CMD_BLACK)
                        begin
                            black_reg <= scan_in;
                        end
                    end
                end
                ST_CH_SETUP:
                begin
                    state_reg <= (level_zero || level_full) ? ST_CH_ACC : ST_CH_DIV;
                end
                ST_CH_DIV:
                begin
                    if (div_last)
                    begin
                        state_reg <= ST_CH_ACC;
                    end
                end
                ST_CH_ACC:
                begin
                    if (ch_reg == lps_pkg::CH_W'(lps_pkg::CHANNELS - 1))
                    begin
                        state_reg <= ST_AVG_SETUP;
                    end
                    else
                    begin
                        state_reg <= ST_CH_SETUP;
                    end
                end
                ST_AVG_SETUP:
                begin
                    state_reg <= ST_AVG_DIV;
                end
                ST_AVG_DIV:
                begin
                    state_reg <= ST_AVG_DONE;
                end
                ST_AVG_DONE:
                begin
                    smoothed_reg <= smoothed_next;
                    state_reg    <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_SPEED;
                end
                ST_SPEED:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    scan_reg  <= scan_in;
                    ch_reg    <= '0;
                    acc_reg   <= '0;
                    left_reg  <= '0;
                    right_reg <= '0;
                end
            end
            ST_CH_SETUP:
            begin
                if (level_zero)
                begin
                    q_reg <= '0;
                end
                else if (level_full)
                begin
                    q_reg <= lps_pkg::Q15_ONE;
                end
                else
                begin
                    rem_reg     <= lps_pkg::DVS_W'(num_mag);
                    divisor_reg <= lps_pkg::DVS_W'(span_mag);
                    quo_reg     <= '0;
                    cnt_reg     <= lps_pkg::CNT_W'(lps_pkg::Q15_BITS);
                end
            end
            ST_CH_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - lps_pkg::CNT_W'(1);
                if (div_last)
                begin
                    q_reg <= lps_pkg::Q15_W'(quo_next[lps_pkg::Q15_BITS-1:0]);
                end
            end
            ST_CH_ACC:
            begin
                acc_reg <= acc_reg + term;
                ch_reg  <= ch_reg + lps_pkg::CH_W'(1);
            end
            ST_AVG_SETUP:
            begin
                neg_reg <= t_sum[lps_pkg::T_W-1];
                quo_reg <= lps_pkg::DIV_W'(t_mag);
            end
            ST_AVG_DIV:
            begin
                quo_reg <= lps_pkg::DIV_W'(
                    recip_prod[lps_pkg::RECIP_PROD_W-1:lps_pkg::AVG_RECIP_SHIFT]);
            end
            ST_MUL:
            begin
                prod_reg <= smoothed_reg * gain_s;
            end
            ST_SPEED:
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
            end
            default:
            begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= lps_pkg::GAIN_RESET;
            base_reg <= lps_pkg::BASE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lps_pkg::REG_STEER_GAIN: gain_reg <= cfg_data[lps_pkg::GAIN_W-1:0];
                lps_pkg::REG_BASE_SPEED: base_reg <= cfg_data[lps_pkg::SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    `LPS_ASSERT_RST(a_reset_no_result, !rst_n |=> !out_valid, "result valid after reset")

    `LPS_ASSERT(a_busy_after_transfer, in_xfer |=> !in_ready, "scan taken while still busy")

    `LPS_ASSERT(a_div_remainder, (state_reg == ST_CH_DIV) |-> (rem_reg < divisor_reg), "divider remainder not below divisor")

    `LPS_ASSERT(a_speed_limit, out_valid |-> (out_data.left_speed <= base_reg && out_data.right_speed <= base_reg), "wheel speed above base speed")

    `LPS_ASSERT(a_position_bound, out_valid |-> (lps_pkg::T_W'(out_data.position) <= lps_pkg::POS_BOUND && lps_pkg::T_W'(out_data.position) >= -lps_pkg::POS_BOUND), "position outside centroid range")

endmodule
